/* hdl/go_to_pose_parking_controller_core_defines.svh */
// ----------------------------------------------------------------------------
// Go-to-pose parking controller: assertion macros
// Shared assertion forms used at the end of the modules that check themselves.
// ----------------------------------------------------------------------------
`ifndef GO_TO_POSE_PARKING_CONTROLLER_CORE_DEFINES_SVH
`define GO_TO_POSE_PARKING_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GPP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/gpp_pkg.sv */
// ----------------------------------------------------------------------------
// Go-to-pose parking controller package
// Fixed-point constants, CORDIC angle table and shared types.
// ----------------------------------------------------------------------------
package gpp_pkg;

    localparam int FRAC_BITS    = 12;
    localparam int CORDIC_STEPS = 16;
    localparam int GUARD        = 8;
    localparam int ANG_SHIFT    = 30 - FRAC_BITS;
    localparam int MAG_SHIFT    = 30 + GUARD;
    localparam int DW           = 17;   // goal minus pose
    localparam int CW           = 28;   // CORDIC x and y
    localparam int ZW           = 34;   // CORDIC angle, Q30
    localparam int MAGW         = 18;
    localparam int ANGW         = 16;
    localparam int ITW          = $clog2(CORDIC_STEPS);
    localparam int INVW         = 31;
    localparam int PW           = CW + INVW;

    localparam longint SCALE = longint'(1) << FRAC_BITS;

    localparam logic signed [17:0] PI_Q =
        18'((64'd3141592654 * SCALE + 64'd500000000) / 64'd1000000000);
    localparam logic signed [17:0] TWO_PI_Q = 18'(2 * PI_Q);
    localparam logic [MAGW-1:0] PARK_IN_D  = MAGW'((20 * SCALE + 500) / 1000);
    localparam logic [MAGW-1:0] PARK_OUT_D = MAGW'((50 * SCALE + 500) / 1000);
    localparam logic signed [17:0] ALIGN_TOL = 18'((80 * SCALE + 500) / 1000);
    localparam logic signed [17:0] BEAR_TOL  = 18'((150 * SCALE + 500) / 1000);
    localparam logic [20:0] SPEED_MAX = 21'((150 * SCALE + 500) / 1000);
    localparam logic signed [11:0] ALIGN_RATE = 12'((250 * SCALE + 500) / 1000);
    localparam logic signed [11:0] SPIN_RATE  = 12'((350 * SCALE + 500) / 1000);

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'd1686629713);
    localparam logic signed [INVW-1:0] INV_GAIN_Q30 = INVW'(64'd652032874);

    localparam logic signed [ZW-1:0] ATAN_TAB [24] = '{
        ZW'(843314857), ZW'(497837829), ZW'(263043837), ZW'(133525159),
        ZW'(67021687),  ZW'(33543516),  ZW'(16775851),  ZW'(8388437),
        ZW'(4194283),   ZW'(2097149),   ZW'(1048576),   ZW'(524288),
        ZW'(262144),    ZW'(131072),    ZW'(65536),     ZW'(32768),
        ZW'(16384),     ZW'(8192),      ZW'(4096),      ZW'(2048),
        ZW'(1024),      ZW'(512),       ZW'(256),       ZW'(128)
    };

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_LOAD = 2'd1;
    localparam logic [1:0] CMD_RAIL = 2'd2;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_LOAD = 2'd1;
    localparam logic [1:0] MODE_RAIL = 2'd2;

    localparam logic [2:0] REG_LOAD_X = 3'd0;
    localparam logic [2:0] REG_LOAD_Y = 3'd1;
    localparam logic [2:0] REG_LOAD_H = 3'd2;
    localparam logic [2:0] REG_RAIL_X = 3'd3;
    localparam logic [2:0] REG_RAIL_Y = 3'd4;
    localparam logic [2:0] REG_RAIL_H = 3'd5;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [14:0] h;
    } t_goal;

    typedef struct packed {
        logic [MAGW-1:0]        mag;
        logic signed [ANGW-1:0] ang;
    } t_polar;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [ITW-1:0] i);
        return ATAN_TAB[i];
    endfunction

endpackage

/* hdl/gpp_regs.sv */
// ----------------------------------------------------------------------------
// Goal register file
// APB-style access to the load and rail station goal poses.
// ----------------------------------------------------------------------------
module gpp_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output gpp_pkg::t_goal o_load,
    output gpp_pkg::t_goal o_rail
);
    import gpp_pkg::*;

    t_goal r_load, r_rail;
    logic  wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= '{x: 16'sd131, y: 16'sd152, h: 15'sd8};
            r_rail <= '{x: 16'sd3613, y: -16'sd1212, h: -15'sd33};
        end else if (wr) begin
            unique case (paddr[4:2])
                REG_LOAD_X: r_load.x <= pwdata[15:0];
                REG_LOAD_Y: r_load.y <= pwdata[15:0];
                REG_LOAD_H: r_load.h <= pwdata[14:0];
                REG_RAIL_X: r_rail.x <= pwdata[15:0];
                REG_RAIL_Y: r_rail.y <= pwdata[15:0];
                REG_RAIL_H: r_rail.h <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_LOAD_X: prdata = {16'd0, r_load.x};
            REG_LOAD_Y: prdata = {16'd0, r_load.y};
            REG_LOAD_H: prdata = {17'd0, r_load.h};
            REG_RAIL_X: prdata = {16'd0, r_rail.x};
            REG_RAIL_Y: prdata = {16'd0, r_rail.y};
            REG_RAIL_H: prdata = {17'd0, r_rail.h};
            default:    prdata = 32'd0;
        endcase
    end

    assign o_load = r_load;
    assign o_rail = r_rail;

endmodule

/* hdl/gpp_cordic.sv */
// ----------------------------------------------------------------------------
// Iterative vectoring CORDIC
// One micro-rotation per cycle, then gain correction and rounding.
// ----------------------------------------------------------------------------
`include "go_to_pose_parking_controller_core_defines.svh"

module gpp_cordic (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [gpp_pkg::DW-1:0] i_dx,
    input  logic signed [gpp_pkg::DW-1:0] i_dy,
    output logic                          o_done,
    output gpp_pkg::t_polar               o_res
);
    import gpp_pkg::*;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_ROT  = 2'd1;
    localparam logic [1:0] C_MUL  = 2'd2;
    localparam logic [1:0] C_RND  = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [ITW-1:0]       r_it;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic                 r_zero;
    logic signed [PW-1:0] r_prod;

    logic signed [CW-1:0] x0, y0, xs, ys;
    logic signed [PW-1:0] mag_r;
    logic signed [ZW-1:0] ang_r;
    logic                 last;

    assign x0   = CW'(i_dx) <<< GUARD;
    assign y0   = CW'(i_dy) <<< GUARD;
    assign xs   = r_x >>> r_it;
    assign ys   = r_y >>> r_it;
    assign last = (r_it == ITW'(CORDIC_STEPS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE: if (i_start) n_state = C_ROT;
            C_ROT:  if (last) n_state = C_MUL;
            C_MUL:  n_state = C_RND;
            C_RND:  n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_it    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == C_ROT) r_it <= r_it + 1'b1;
            else                  r_it <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE && i_start) begin
            r_zero <= (i_dx == '0) && (i_dy == '0);
            // Bring the vector into the right half plane by an exact quarter turn.
            if (x0 < 0) begin
                if (y0 >= 0) begin
                    r_x <= y0;
                    r_y <= -x0;
                    r_z <= HALF_PI_Q30;
                end else begin
                    r_x <= -y0;
                    r_y <= x0;
                    r_z <= -HALF_PI_Q30;
                end
            end else begin
                r_x <= x0;
                r_y <= y0;
                r_z <= '0;
            end
        end else if (r_state == C_ROT) begin
            if (r_y > 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_q30(r_it);
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_q30(r_it);
            end
        end
        if (r_state == C_MUL) begin
            r_prod <= PW'(r_x) * PW'(INV_GAIN_Q30);
        end
    end

    assign mag_r  = r_prod + (PW'(1) <<< (MAG_SHIFT - 1));
    assign ang_r  = r_z + (ZW'(1) <<< (ANG_SHIFT - 1));
    assign o_done = (r_state == C_RND);
    assign o_res.mag = mag_r[MAG_SHIFT +: MAGW];
    assign o_res.ang = r_zero ? '0 : ang_r[ANG_SHIFT +: ANGW];

    `GPP_ASSERT_NOW(a_start_idle, i_start, r_state == C_IDLE, "CORDIC started while busy")
    `GPP_ASSERT_NEXT(a_rot_to_mul, r_state == C_ROT && last, r_state == C_MUL, "rotation overran")
    `GPP_ASSERT_NEXT(a_mul_to_rnd, r_state == C_MUL, o_done, "rounding step skipped")
    `GPP_ASSERT_NOW(a_x_pos, r_state == C_MUL, !r_x[CW-1], "negative CORDIC magnitude")

endmodule

/* hdl/go_to_pose_parking_controller_core.sv */
// ----------------------------------------------------------------------------
// Go-to-pose parking controller core
// Turn, drive and align controller toward a configured station pose.
// ----------------------------------------------------------------------------
// A go-to-load or go-to-rail command is taken only while the block is idle;
// it selects the goal pose and clears the parking flag, and produces no output
// word. Each later pose tick with a valid pose runs a vectoring CORDIC on the
// goal offset, one micro-rotation per clock through a single shared
// add/shift datapath, followed by one gain-correction multiply and a rounding
// step. The output word is registered after these steps in order: the
// accepting edge loads the CORDIC, then the CORDIC_STEPS rotations, the
// multiply, the rounding step and the drive decision follow, the last once
// the output register is free. o_in_stall stays high until the word is
// loaded into the output register, so the next item is accepted only after
// that, and later while an earlier word still waits under a stall. Commands
// and ignored ticks are accepted without leaving idle. The output word sits
// in a register, so the next item can be accepted while it waits to be taken.
// Goal registers live at byte addresses 0 to 20 of the APB-style port.
`include "go_to_pose_parking_controller_core_defines.svh"

module go_to_pose_parking_controller_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_command,
    input  logic               i_pose_valid,
    input  logic signed [15:0] i_pose_x,
    input  logic signed [15:0] i_pose_y,
    input  logic signed [14:0] i_pose_heading,
    // Output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [9:0]         o_linear_speed,
    output logic signed [11:0] o_turn_rate,
    output logic               o_done_valid,
    output logic               o_done_station,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import gpp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CORD = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    t_goal  load_goal, rail_goal, goal;
    t_polar cres;
    logic   cdone, accept, start;

    logic [1:0]          r_state, r_mode;
    logic                r_parking;
    logic signed [14:0]  r_ph, r_gh;
    logic [MAGW-1:0]     r_dist;
    logic signed [ANGW-1:0] r_bear;

    logic                r_out_valid, r_done, r_station;
    logic [9:0]          r_speed;
    logic signed [11:0]  r_turn;

    logic signed [DW-1:0] dx, dy;
    logic signed [17:0]   err_raw, err, ferr_raw, ferr;
    logic                 park_next, aligned, load_out;
    logic [20:0]          speed_g;
    logic signed [20:0]   turn_g;
    logic [9:0]           n_speed;
    logic signed [11:0]   n_turn;

    gpp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_load  (load_goal),
        .o_rail  (rail_goal)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign start      = accept && (i_command == CMD_TICK) && i_pose_valid
                        && (r_mode != MODE_IDLE);

    assign goal = (r_mode == MODE_RAIL) ? rail_goal : load_goal;
    assign dx   = DW'(goal.x) - DW'(i_pose_x);
    assign dy   = DW'(goal.y) - DW'(i_pose_y);

    gpp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_dx    (dx),
        .i_dy    (dy),
        .o_done  (cdone),
        .o_res   (cres)
    );

    // Heading errors wrapped into minus pi to pi; one correction always suffices.
    assign err_raw  = 18'(r_bear) - 18'(r_ph);
    assign ferr_raw = 18'(r_gh) - 18'(r_ph);

    always_comb begin
        priority if (err_raw > PI_Q)       err = err_raw - TWO_PI_Q;
        else if (err_raw < -PI_Q)          err = err_raw + TWO_PI_Q;
        else                               err = err_raw;
        priority if (ferr_raw > PI_Q)      ferr = ferr_raw - TWO_PI_Q;
        else if (ferr_raw < -PI_Q)         ferr = ferr_raw + TWO_PI_Q;
        else                               ferr = ferr_raw;
    end

    // Parking is entered close to the goal and left only well outside it.
    always_comb begin
        priority if (!r_parking && r_dist <= PARK_IN_D) park_next = 1'b1;
        else if (r_parking && r_dist > PARK_OUT_D)      park_next = 1'b0;
        else                                            park_next = r_parking;
    end

    // Gain of 1.5, rounded to nearest with ties upward.
    assign speed_g = (21'(r_dist) * 21'd3 + 21'd1) >> 1;
    assign turn_g  = (21'(err) * 21'sd3 + 21'sd1) >>> 1;
    assign aligned = !(ferr > ALIGN_TOL || ferr < -ALIGN_TOL);

    always_comb begin
        n_speed = '0;
        n_turn  = '0;
        if (park_next) begin
            if (!aligned) n_turn = (ferr > 0) ? ALIGN_RATE : -ALIGN_RATE;
        end else if (err > BEAR_TOL || err < -BEAR_TOL) begin
            n_turn = (err > 0) ? SPIN_RATE : -SPIN_RATE;
        end else begin
            n_speed = (speed_g > SPEED_MAX) ? SPEED_MAX[9:0] : speed_g[9:0];
            n_turn  = turn_g[11:0];
        end
    end

    assign load_out = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_IDLE;
            r_parking   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A new word fills the register; a waiting word stays while stalled.
            r_out_valid <= load_out || (r_out_valid && i_out_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (accept && r_mode == MODE_IDLE
                        && (i_command == CMD_LOAD || i_command == CMD_RAIL)) begin
                        r_mode    <= (i_command == CMD_LOAD) ? MODE_LOAD : MODE_RAIL;
                        r_parking <= 1'b0;
                    end
                    if (start) r_state <= S_CORD;
                end
                S_CORD: if (cdone) r_state <= S_OUT;
                S_OUT: begin
                    if (load_out) begin
                        r_state     <= S_IDLE;
                        if (park_next && aligned) begin
                            r_parking <= 1'b0;
                            r_mode    <= MODE_IDLE;
                        end else begin
                            r_parking <= park_next;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_ph <= i_pose_heading;
            r_gh <= goal.h;
        end
        if (cdone) begin
            r_dist <= cres.mag;
            r_bear <= cres.ang;
        end
        if (load_out) begin
            r_speed   <= n_speed;
            r_turn    <= n_turn;
            r_done    <= park_next && aligned;
            r_station <= park_next && aligned && (r_mode == MODE_RAIL);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_linear_speed = r_speed;
    assign o_turn_rate    = r_turn;
    assign o_done_valid   = r_done;
    assign o_done_station = r_station;

    `GPP_ASSERT_NOW(a_out_src, $rose(o_out_valid), $past(r_state) == S_OUT, "stray output word")
    `GPP_ASSERT_NOW(a_done_stop, o_out_valid && o_done_valid,
        o_linear_speed == 10'd0 && o_turn_rate == 12'sd0, "completion with nonzero drive")
    `GPP_ASSERT_NOW(a_busy_mode, r_state != S_IDLE, r_mode != MODE_IDLE, "busy with no goal")

endmodule
